// File: rtl/core/cna_pkg.sv
// ----------------------------------------------------------------------------
// Complex number ALU package
// Mode and status codes, step counts, angle and saturation constants, the
// arctangent table and the record carried down the iterative pipeline.
// ----------------------------------------------------------------------------
package cna_pkg;

  // Operation selected by the transaction's tuser field.
  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_MUL   = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_CONJ  = 4'd4,
    MODE_MAG   = 4'd5,
    MODE_ANGLE = 4'd6,
    MODE_REAL  = 4'd7,
    MODE_IMAG  = 4'd8,
    MODE_POLAR = 4'd9
  } mode_t;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_MODE = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  // Step counts of the iterative units.
  localparam int DIV_STEPS    = 33;
  localparam int SQRT_STEPS   = 24;
  localparam int CORDIC_STEPS = 16;

  // Angles in Q16.16 degrees.
  localparam logic signed [31:0] DEG_90  = 32'sd5898240;
  localparam logic signed [31:0] DEG_180 = 32'sd11796480;
  localparam logic signed [31:0] DEG_270 = 32'sd17694720;
  localparam logic signed [31:0] DEG_360 = 32'sd23592960;

  // Saturation limits.
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  // Arctangent of 2^-i in Q16.16 degrees.
  function automatic logic signed [31:0] atan_deg(input int idx);
    logic signed [31:0] val;
    unique case (idx)
      0:       val = 32'sd2949120;
      1:       val = 32'sd1740967;
      2:       val = 32'sd919879;
      3:       val = 32'sd466945;
      4:       val = 32'sd234379;
      5:       val = 32'sd117304;
      6:       val = 32'sd58666;
      7:       val = 32'sd29335;
      8:       val = 32'sd14668;
      9:       val = 32'sd7334;
      10:      val = 32'sd3667;
      11:      val = 32'sd1833;
      12:      val = 32'sd917;
      13:      val = 32'sd458;
      14:      val = 32'sd229;
      default: val = 32'sd115;
    endcase
    return val;
  endfunction

  // Record carried through the divider, square root and CORDIC stages.
  typedef struct packed {
    logic [3:0]         mode;
    logic [31:0]        sres_re;
    logic [31:0]        sres_im;
    logic               ssat;
    logic               re_neg;
    logic               im_neg;
    logic               dzero;
    logic               ovf_re;
    logic               ovf_im;
    logic [32:0]        dvs;
    logic [48:0]        num_re;
    logic [48:0]        num_im;
    logic [33:0]        rem_re;
    logic [33:0]        rem_im;
    logic [32:0]        q_re;
    logic [32:0]        q_im;
    logic [47:0]        sx;
    logic [47:0]        sr;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [31:0] cz;
    logic               ang_spec;
    logic [31:0]        ang_val;
  } step_t;

endpackage

// File: rtl/core/complex_number_alu.sv
// Transactions pass the input, product, sum, prep, step and output registers.
// Throughput: one transaction per cycle; the 33-step restoring divider sets
// the depth, with the 24-step square root and 16-step CORDIC in its stages.
// The whole pipeline advances together and stalls while the output waits.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
// Complex number ALU
// Pipelined add, subtract, multiply, divide, conjugate, magnitude, angle,
// real, imaginary and polar operations on Q8.8 operands, Q16.16 results.
// ----------------------------------------------------------------------------
module complex_number_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // a_real [15:0], a_imag [31:16], b_real [47:32], b_imag [63:48]
  input  logic [63:0] s_tdata,
  // mode [3:0]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // res_real [31:0], res_imag [63:32], status [65:64], zero pad [71:66]
  output logic [71:0] m_tdata
);

  localparam int NS = cna_pkg::DIV_STEPS;

  logic ce;

  // Input register.
  logic              v0;
  logic [3:0]        mode0;
  logic signed [15:0] ar0, ai0, br0, bi0;

  // Product stage.
  logic              v1;
  logic [3:0]        mode1;
  logic signed [15:0] ar1, ai1, br1, bi1;
  logic signed [31:0] p_arbr, p_aibi, p_arbi, p_aibr, p_brbr, p_bibi, p_arar, p_aiai;

  // Sum stage.
  logic              v2;
  logic [3:0]        mode2;
  logic signed [15:0] ar2, ai2;
  logic [31:0]       sres_re2, sres_im2;
  logic              ssat2;
  logic [31:0]       nre_mag2, nim_mag2, d2, ssum2;
  logic              re_neg2, im_neg2;

  // Iterative stages.
  cna_pkg::step_t stg     [0:NS];
  cna_pkg::step_t stg_nxt [0:NS];
  logic           vs      [0:NS];

  // Output register.
  logic [31:0] out_re, out_im;
  logic [1:0]  out_st;

  // The pipeline moves whenever the output register is free or being taken.
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Input capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ce) begin
      v0 <= s_tvalid;
    end
    if (ce) begin
      mode0 <= s_tuser;
      ar0   <= s_tdata[15:0];
      ai0   <= s_tdata[31:16];
      br0   <= s_tdata[47:32];
      bi0   <= s_tdata[63:48];
    end
  end

  // All eight operand products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= v0;
    end
    if (ce) begin
      mode1  <= mode0;
      ar1    <= ar0;
      ai1    <= ai0;
      br1    <= br0;
      bi1    <= bi0;
      p_arbr <= ar0 * br0;
      p_aibi <= ai0 * bi0;
      p_arbi <= ar0 * bi0;
      p_aibr <= ai0 * br0;
      p_brbr <= br0 * br0;
      p_bibi <= bi0 * bi0;
      p_arar <= ar0 * ar0;
      p_aiai <= ai0 * ai0;
    end
  end

  // Direct results, divide numerators and sums of squares.
  logic signed [32:0] mul_re, mul_im, nre, nim;
  logic signed [16:0] sum_re, sum_im, dif_re, dif_im;
  logic [31:0]        sre_c, sim_c;
  logic               ssat_c;

  always_comb begin
    mul_re = 33'(p_arbr) - 33'(p_aibi);
    mul_im = 33'(p_arbi) + 33'(p_aibr);
    nre    = 33'(p_arbr) + 33'(p_aibi);
    nim    = 33'(p_aibr) - 33'(p_arbi);
    sum_re = 17'(ar1) + 17'(br1);
    sum_im = 17'(ai1) + 17'(bi1);
    dif_re = 17'(ar1) - 17'(br1);
    dif_im = 17'(ai1) - 17'(bi1);
    sre_c  = '0;
    sim_c  = '0;
    ssat_c = 1'b0;
    unique case (mode1)
      cna_pkg::MODE_ADD: begin
        sre_c = 32'({sum_re, 8'b0});
        sim_c = 32'({sum_im, 8'b0});
        sre_c = {{7{sum_re[16]}}, sum_re, 8'b0};
        sim_c = {{7{sum_im[16]}}, sum_im, 8'b0};
      end
      cna_pkg::MODE_SUB: begin
        sre_c = {{7{dif_re[16]}}, dif_re, 8'b0};
        sim_c = {{7{dif_im[16]}}, dif_im, 8'b0};
      end
      cna_pkg::MODE_MUL: begin
        // Saturate the 33-bit exact products to 32 bits.
        if (mul_re[32] != mul_re[31]) begin
          sre_c  = mul_re[32] ? cna_pkg::NEG_MIN : cna_pkg::POS_MAX;
          ssat_c = 1'b1;
        end else begin
          sre_c = mul_re[31:0];
        end
        if (mul_im[32] != mul_im[31]) begin
          sim_c  = mul_im[32] ? cna_pkg::NEG_MIN : cna_pkg::POS_MAX;
          ssat_c = 1'b1;
        end else begin
          sim_c = mul_im[31:0];
        end
      end
      cna_pkg::MODE_CONJ: begin
        sre_c = {{8{ar1[15]}}, ar1, 8'b0};
        sim_c = 32'(-(33'(ai1) <<< 8));
      end
      cna_pkg::MODE_REAL: begin
        sre_c = {{8{ar1[15]}}, ar1, 8'b0};
      end
      cna_pkg::MODE_IMAG: begin
        sim_c = {{8{ai1[15]}}, ai1, 8'b0};
      end
      default: begin
        sre_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
    if (ce) begin
      mode2    <= mode1;
      ar2      <= ar1;
      ai2      <= ai1;
      sres_re2 <= sre_c;
      sres_im2 <= sim_c;
      ssat2    <= ssat_c;
      re_neg2  <= nre[32];
      im_neg2  <= nim[32];
      nre_mag2 <= nre[32] ? 32'(-nre) : nre[31:0];
      nim_mag2 <= nim[32] ? 32'(-nim) : nim[31:0];
      d2       <= p_brbr + p_bibi;
      ssum2    <= p_arar + p_aiai;
    end
  end

  // Preparation of the divider, square root and CORDIC operands.
  always_comb begin
    cna_pkg::step_t p;
    p          = '0;
    p.mode     = mode2;
    p.sres_re  = sres_re2;
    p.sres_im  = sres_im2;
    p.ssat     = ssat2;
    p.re_neg   = re_neg2;
    p.im_neg   = im_neg2;
    p.dzero    = (d2 == '0);
    p.dvs      = {d2, 1'b0};
    // Rounded quotient: (|n| * 2^17 + d) / (2d).
    p.num_re   = {nre_mag2, 17'b0} + {17'b0, d2};
    p.num_im   = {nim_mag2, 17'b0} + {17'b0, d2};
    p.ovf_re   = {16'b0, p.num_re[48:32]} >= p.dvs;
    p.ovf_im   = {16'b0, p.num_im[48:32]} >= p.dvs;
    p.rem_re   = {18'b0, p.num_re[48:33]};
    p.rem_im   = {18'b0, p.num_im[48:33]};
    p.q_re     = '0;
    p.q_im     = '0;
    p.sx       = {ssum2, 16'b0};
    p.sr       = '0;
    // CORDIC start, turned into the right half plane.
    p.cx       = {{4{ar2[15]}}, ar2, 16'b0};
    p.cy       = {{4{ai2[15]}}, ai2, 16'b0};
    p.cz       = '0;
    if (ar2[15]) begin
      p.cx = -p.cx;
      p.cy = -p.cy;
      p.cz = cna_pkg::DEG_180;
    end
    // Zero and axis operands have exact angles.
    p.ang_spec = 1'b1;
    if (ar2 == '0 && ai2 == '0) begin
      p.ang_val = '0;
    end else if (ai2 == '0) begin
      p.ang_val = ar2[15] ? cna_pkg::DEG_180 : '0;
    end else if (ar2 == '0) begin
      p.ang_val = ai2[15] ? cna_pkg::DEG_270 : cna_pkg::DEG_90;
    end else begin
      p.ang_spec = 1'b0;
      p.ang_val  = '0;
    end
    stg_nxt[0] = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (ce) begin
      vs[0] <= v2;
    end
    if (ce) begin
      stg[0] <= stg_nxt[0];
    end
  end

  // One quotient bit per stage, plus a root bit and a rotation in the stages that the square root and CORDIC use.
  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int BITIDX = NS - 1 - k;

    always_comb begin
      cna_pkg::step_t s;
      logic [33:0] t_re, t_im;
      logic [47:0] rbit;
      logic signed [35:0] dx, dy;
      s    = stg[k];
      // Restoring division step for both quotients.
      t_re = {stg[k].rem_re[32:0], stg[k].num_re[BITIDX]};
      t_im = {stg[k].rem_im[32:0], stg[k].num_im[BITIDX]};
      if (t_re >= {1'b0, stg[k].dvs}) begin
        s.rem_re = t_re - {1'b0, stg[k].dvs};
        s.q_re   = {stg[k].q_re[31:0], 1'b1};
      end else begin
        s.rem_re = t_re;
        s.q_re   = {stg[k].q_re[31:0], 1'b0};
      end
      if (t_im >= {1'b0, stg[k].dvs}) begin
        s.rem_im = t_im - {1'b0, stg[k].dvs};
        s.q_im   = {stg[k].q_im[31:0], 1'b1};
      end else begin
        s.rem_im = t_im;
        s.q_im   = {stg[k].q_im[31:0], 1'b0};
      end
      rbit = '0;
      dx   = '0;
      dy   = '0;
      // Digit-by-digit square root step.
      if (k < cna_pkg::SQRT_STEPS) begin
        rbit = 48'(1) << (46 - 2 * k);
        if (stg[k].sx >= stg[k].sr + rbit) begin
          s.sx = stg[k].sx - (stg[k].sr + rbit);
          s.sr = (stg[k].sr >> 1) + rbit;
        end else begin
          s.sr = stg[k].sr >> 1;
        end
      end
      // CORDIC vectoring rotation.
      if (k < cna_pkg::CORDIC_STEPS) begin
        dy = stg[k].cy >>> k;
        dx = stg[k].cx >>> k;
        if (!stg[k].cy[35]) begin
          s.cx = stg[k].cx + dy;
          s.cy = stg[k].cy - dx;
          s.cz = stg[k].cz + cna_pkg::atan_deg(k);
        end else begin
          s.cx = stg[k].cx - dy;
          s.cy = stg[k].cy + dx;
          s.cz = stg[k].cz - cna_pkg::atan_deg(k);
        end
      end
      stg_nxt[k + 1] = s;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k + 1] <= 1'b0;
      end else if (ce) begin
        vs[k + 1] <= vs[k];
      end
      if (ce) begin
        stg[k + 1] <= stg_nxt[k + 1];
      end
    end
  end

  // Sign, saturation, wrap and mode selection.
  logic [31:0] div_re, div_im, mag, ang, re_next, im_next;
  logic        dsat_re, dsat_im, sat;
  logic [1:0]  st_next;
  logic signed [31:0] zw;

  always_comb begin
    cna_pkg::step_t f;
    f = stg[NS];
    if (f.re_neg) begin
      dsat_re = f.ovf_re || (f.q_re > 33'(cna_pkg::NEG_MIN));
      div_re  = dsat_re ? cna_pkg::NEG_MIN : 32'(-f.q_re[31:0]);
    end else begin
      dsat_re = f.ovf_re || (f.q_re > 33'(cna_pkg::POS_MAX));
      div_re  = dsat_re ? cna_pkg::POS_MAX : f.q_re[31:0];
    end
    if (f.im_neg) begin
      dsat_im = f.ovf_im || (f.q_im > 33'(cna_pkg::NEG_MIN));
      div_im  = dsat_im ? cna_pkg::NEG_MIN : 32'(-f.q_im[31:0]);
    end else begin
      dsat_im = f.ovf_im || (f.q_im > 33'(cna_pkg::POS_MAX));
      div_im  = dsat_im ? cna_pkg::POS_MAX : f.q_im[31:0];
    end
    // Round the root to nearest.
    mag = f.sr[31:0] + 32'(f.sx > f.sr);
    zw  = f.cz;
    if (zw < 0) begin
      zw = zw + cna_pkg::DEG_360;
    end else if (zw >= cna_pkg::DEG_360) begin
      zw = zw - cna_pkg::DEG_360;
    end
    ang = f.ang_spec ? f.ang_val : zw;

    re_next = f.sres_re;
    im_next = f.sres_im;
    sat     = f.ssat;
    st_next = cna_pkg::ST_OK;
    unique case (f.mode)
      cna_pkg::MODE_ADD, cna_pkg::MODE_SUB, cna_pkg::MODE_MUL, cna_pkg::MODE_CONJ,
      cna_pkg::MODE_REAL, cna_pkg::MODE_IMAG: begin
        re_next = f.sres_re;
      end
      cna_pkg::MODE_DIV: begin
        if (f.dzero) begin
          re_next = '0;
          im_next = '0;
          sat     = 1'b0;
          st_next = cna_pkg::ST_DIV_ZERO;
        end else begin
          re_next = div_re;
          im_next = div_im;
          sat     = dsat_re || dsat_im;
        end
      end
      cna_pkg::MODE_MAG: begin
        re_next = mag;
        im_next = '0;
      end
      cna_pkg::MODE_ANGLE: begin
        re_next = '0;
        im_next = ang;
      end
      cna_pkg::MODE_POLAR: begin
        re_next = mag;
        im_next = ang;
      end
      default: begin
        re_next = '0;
        im_next = '0;
        sat     = 1'b0;
        st_next = cna_pkg::ST_BAD_MODE;
      end
    endcase
    if (st_next == cna_pkg::ST_OK && sat) begin
      st_next = cna_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= vs[NS];
    end
    if (ce) begin
      out_re <= re_next;
      out_im <= im_next;
      out_st <= st_next;
    end
  end

  assign m_tdata = {6'b0, out_st, out_im, out_re};

  // A divide by zero returns both fields cleared.
  a_divzero_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_st == cna_pkg::ST_DIV_ZERO |-> out_re == '0 && out_im == '0)
    else $error("divide by zero result not cleared");

  // An accepted transaction enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v0)
    else $error("accepted transaction lost at entry");

  // A stalled pipeline keeps its last iterative stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(vs[NS]) && $stable(stg[NS]))
    else $error("pipeline moved during a stall");

  // Angles leave the final stage inside one turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    vs[NS] && (stg[NS].mode == cna_pkg::MODE_ANGLE || stg[NS].mode == cna_pkg::MODE_POLAR)
    |-> !ang[31] && $signed(ang) < cna_pkg::DEG_360)
    else $error("angle out of range");

endmodule
